[rtl/fts_pkg.sv]
// Shared types and constants for the FIFO thread scheduler.
`default_nettype none

package fts_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_YIELD = 2'd1,
    REQ_TERM  = 2'd2,
    REQ_DISK  = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Register indexes
  localparam logic REG_DISK_ATTACHED = 1'b0;

  // Control of one queue, shared by all its cells
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               del_en;
    logic [ID_BITS-1:0] id;
  } qctl_t;

  // Status of one queue back to the controller
  typedef struct packed {
    logic               empty;
    logic               full;
    logic               found;
    logic [ID_BITS-1:0] head;
    logic [CNT_W-1:0]   fill_next;
  } qstat_t;

endpackage

`default_nettype wire

[rtl/fifo_thread_scheduler_with_io_priority.sv]
// Top level: request decode, two cell-chain queues, result register, APB register.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------------
//  in      | in        | in_valid/ready   | req_type, thread_id, disk_ready
//  out     | out       | out_valid/ready  | dispatched, dispatched_id, from_disk_queue,
//          |           |                  | status, ready_count, disk_count
//  apb     | in        | psel/penable     | paddr, pwdata, prdata (disk_attached)
//
// Add, yield and disk enqueue have their result registered at the accepting
// edge. Terminate removes one matching id per cycle in the ready cell row; its
// result is registered once the row holds no further match, and input is held
// off until then. Input is taken when the controller is idle and the result
// register is empty or being drained. Reset is synchronous and empties both
// queues and clears disk_attached.
`default_nettype none

module fifo_thread_scheduler_with_io_priority
  import fts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  thread_id,
  input  wire logic        disk_ready,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             dispatched,
  output logic [7:0]       dispatched_id,
  output logic             from_disk_queue,
  output logic [1:0]       status,
  output logic [4:0]       ready_count,
  output logic [4:0]       disk_count,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DEL  = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  logic               disk_attached;
  logic [ID_BITS-1:0] del_id;
  logic               acc;
  logic [ID_BITS-1:0] in_id;
  logic               is_add;
  logic               is_yield;
  logic               is_term;
  logic               is_disk;
  logic               sel_disk;
  logic               sel_ready;
  logic               load;
  qctl_t              rq_ctl;
  qctl_t              dq_ctl;
  qstat_t             rq_stat;
  qstat_t             dq_stat;
  logic               res_disp;
  logic [7:0]         res_id;
  logic               res_from_disk;
  status_t            res_status;

  // Register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_attached <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DISK_ATTACHED) begin
      disk_attached <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_DISK_ATTACHED) ? {31'd0, disk_attached} : 32'd0;

  // Request decode
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid & in_ready;
  assign in_id    = ID_BITS'(thread_id);
  assign is_add   = (req_type == REQ_ADD);
  assign is_yield = (req_type == REQ_YIELD);
  assign is_term  = (req_type == REQ_TERM);
  assign is_disk  = (req_type == REQ_DISK);

  // Yield source: disk queue has priority when attached and ready
  assign sel_disk  = disk_attached & disk_ready & ~dq_stat.empty;
  assign sel_ready = ~sel_disk & ~rq_stat.empty;

  // Queue control
  always_comb begin
    rq_ctl.push   = acc & is_add;
    rq_ctl.pop    = acc & is_yield & sel_ready;
    rq_ctl.del_en = (state == S_DEL);
    rq_ctl.id     = (state == S_DEL) ? del_id : in_id;
    dq_ctl.push   = acc & is_disk;
    dq_ctl.pop    = acc & is_yield & sel_disk;
    dq_ctl.del_en = 1'b0;
    dq_ctl.id     = in_id;
  end

  fts_queue u_ready_q (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rq_ctl),
    .stat (rq_stat)
  );

  fts_queue u_disk_q (
    .clk  (clk),
    .rst  (rst),
    .ctl  (dq_ctl),
    .stat (dq_stat)
  );

  // Controller
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && is_term) begin
          state_next = S_DEL;
        end
      end
      S_DEL: begin
        if (!rq_stat.found) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_term) begin
      del_id <= in_id;
    end
  end

  // Result of this item
  always_comb begin
    res_disp      = 1'b0;
    res_id        = 8'd0;
    res_from_disk = 1'b0;
    res_status    = ST_OK;
    if (state == S_IDLE) begin
      if (is_add && rq_stat.full) begin
        res_status = ST_FULL;
      end else if (is_disk && dq_stat.full) begin
        res_status = ST_FULL;
      end else if (is_yield) begin
        if (sel_disk) begin
          res_disp      = 1'b1;
          res_id        = 8'(dq_stat.head);
          res_from_disk = 1'b1;
        end else if (sel_ready) begin
          res_disp = 1'b1;
          res_id   = 8'(rq_stat.head);
        end else begin
          res_status = ST_EMPTY;
        end
      end
    end
  end

  assign load = (acc && !is_term) || (state == S_DEL && !rq_stat.found);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dispatched      <= res_disp;
      dispatched_id   <= res_id;
      from_disk_queue <= res_from_disk;
      status          <= res_status;
      ready_count     <= 5'(rq_stat.fill_next);
      disk_count      <= 5'(dq_stat.fill_next);
    end
  end

endmodule

`default_nettype wire

[rtl/fts_cell.sv]
// One queue cell: holds an id and its valid bit, shifts towards the head.
`default_nettype none

module fts_cell
  import fts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qctl_t              ctl,
  input  wire logic               prev_valid,
  input  wire logic               next_valid,
  input  wire logic [ID_BITS-1:0] next_id,
  input  wire logic               shift_in,
  output logic                    shift_out,
  output logic                    valid,
  output logic [ID_BITS-1:0]      id
);

  logic match;
  logic load;

  // A matching entry is removed: it and everything behind it move up one
  assign match     = ctl.del_en & valid & (id == ctl.id);
  assign shift_out = shift_in | match;
  // First free cell takes a pushed id
  assign load      = ctl.push & ~valid & prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_out) begin
      valid <= next_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_out) begin
      id <= next_id;
    end else if (load) begin
      id <= ctl.id;
    end
  end

endmodule

`default_nettype wire

[rtl/fts_queue.sv]
// FIFO of thread ids built from a row of shifting cells, with fill count.
`default_nettype none

module fts_queue
  import fts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire qctl_t ctl,
  output qstat_t     stat
);

  logic [QUEUE_DEPTH-1:0] valid;
  logic [ID_BITS-1:0]     id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   shift;
  logic [CNT_W-1:0]       fill;
  logic [CNT_W-1:0]       fill_next;
  logic                   full;
  logic                   found;

  // Pop shifts the whole row; removals start their own shift
  assign shift[0] = ctl.pop;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic               prev_v;
    logic               next_v;
    logic [ID_BITS-1:0] next_i;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_i = '0;
    end else begin : g_inner
      assign next_v = valid[i+1];
      assign next_i = id[i+1];
    end

    fts_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_id    (next_i),
      .shift_in   (shift[i]),
      .shift_out  (shift[i+1]),
      .valid      (valid[i]),
      .id         (id[i])
    );
  end

  assign full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign found = ctl.del_en & shift[QUEUE_DEPTH];

  // Fill count: one entry in or out per cycle at most
  always_comb begin
    fill_next = fill;
    if (ctl.push && !full) begin
      fill_next = fill + CNT_W'(1);
    end else if (ctl.pop && valid[0]) begin
      fill_next = fill - CNT_W'(1);
    end else if (found) begin
      fill_next = fill - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  assign stat.empty     = ~valid[0];
  assign stat.full      = full;
  assign stat.found     = found;
  assign stat.head      = id[0];
  assign stat.fill_next = fill_next;

endmodule

`default_nettype wire

[rtl/fts_chk.sv]
// Port-level checks for the thread scheduler, bound to the top level.
`default_nettype none

module fts_chk
  import fts_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       dispatched,
  input wire logic [7:0] dispatched_id,
  input wire logic       from_disk_queue,
  input wire logic [1:0] status,
  input wire logic [4:0] ready_count,
  input wire logic [4:0] disk_count
);

  // A waiting result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dispatched_id) && $stable(status))
    else $error("result changed while stalled");

  // Counts never exceed the queue depth
  a_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ready_count <= 5'(QUEUE_DEPTH)) && (disk_count <= 5'(QUEUE_DEPTH)))
    else $error("queue count out of range");

  // A dispatch always reports success
  a_disp_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispatched |-> status == ST_OK)
    else $error("dispatch with error status");

  // No dispatch means no id and no source
  a_no_disp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dispatched |-> dispatched_id == 8'd0 && !from_disk_queue)
    else $error("id reported without dispatch");

endmodule

bind fifo_thread_scheduler_with_io_priority fts_chk u_fts_chk (.*);

`default_nettype wire

[verif/sched_checker.sv]
// Checker for the thread scheduler: watches both channels and the register port, predicts and compares.
module sched_checker
  import fts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  thread_id,
  input  logic        disk_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        dispatched,
  input  logic [7:0]  dispatched_id,
  input  logic        from_disk_queue,
  input  logic [1:0]  status,
  input  logic [4:0]  ready_count,
  input  logic [4:0]  disk_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          full_drops,
  output int          disk_dispatches
);

  // One predicted result
  typedef struct packed {
    logic             dispatched;
    logic [7:0]       dispatched_id;
    logic             from_disk;
    status_t          status;
    logic [4:0]       ready_count;
    logic [4:0]       disk_count;
  } sched_result_t;

  // Shadow of the block's queues and register
  logic [ID_BITS-1:0] ready_ids[$];
  logic [ID_BITS-1:0] disk_ids[$];
  logic               attached;
  sched_result_t      results_due[$];

  // Apply one request to the shadow queues and work out its result
  function automatic sched_result_t schedule_request(req_t req, logic [ID_BITS-1:0] id,
                                                     logic dready);
    sched_result_t      r;
    logic [ID_BITS-1:0] kept[$];
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_ADD: begin
        if (ready_ids.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else ready_ids.push_back(id);
      end
      REQ_DISK: begin
        if (disk_ids.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else disk_ids.push_back(id);
      end
      REQ_YIELD: begin
        // disk waiters win only when the disk is attached and ready
        if (attached && dready && disk_ids.size() != 0) begin
          r.dispatched    = 1'b1;
          r.dispatched_id = disk_ids.pop_front();
          r.from_disk     = 1'b1;
        end else if (ready_ids.size() != 0) begin
          r.dispatched    = 1'b1;
          r.dispatched_id = ready_ids.pop_front();
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: begin
        // terminate: drop every match, keep the order of the rest
        foreach (ready_ids[k])
          if (ready_ids[k] != id) kept.push_back(ready_ids[k]);
        ready_ids = kept;
      end
    endcase
    r.ready_count = 5'(ready_ids.size());
    r.disk_count  = 5'(disk_ids.size());
    return r;
  endfunction

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Results are taken before requests, so a result can only match an older item
  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      ready_ids.delete();
      disk_ids.delete();
      results_due.delete();
      attached = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_DISK_ATTACHED)
        attached = pwdata[0];
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: result with no item outstanding, expected none, got id %0d",
                   $time, dispatched_id);
        end else begin
          want = results_due.pop_front();
          checked++;
          compare_field("dispatched", want.dispatched, dispatched);
          compare_field("dispatched_id", want.dispatched_id, dispatched_id);
          compare_field("from_disk_queue", want.from_disk, from_disk_queue);
          compare_field("status", want.status, status);
          compare_field("ready_count", want.ready_count, ready_count);
          compare_field("disk_count", want.disk_count, disk_count);
        end
      end
      if (in_valid && in_ready) begin
        want = schedule_request(req_t'(req_type), thread_id, disk_ready);
        if (want.status == ST_FULL) full_drops++;
        if (want.from_disk) disk_dispatches++;
        results_due.push_back(want);
      end
    end
    pending = results_due.size();
  end

endmodule

[verif/testbench.sv]
// Top of the scheduler testbench: clock, reset, request and register stimulus, verdict.
module testbench
  import fts_pkg::*;
();

  localparam int          QUIET_LIMIT  = 3000;
  localparam int          SETTLE       = 20;
  localparam int          SEGMENT_LEN  = 220;
  localparam logic [2:0]  ADDR_DISK_ATTACHED = {REG_DISK_ATTACHED, 2'b00};
  localparam logic [2:0]  ADDR_UNMAPPED      = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_ADD;
  logic [7:0]  thread_id = 8'd0;
  logic        disk_ready = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        dispatched;
  logic [7:0]  dispatched_id;
  logic        from_disk_queue;
  logic [1:0]  status;
  logic [4:0]  ready_count;
  logic [4:0]  disk_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, checked, full_drops, disk_dispatches;
  int sent = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_left = 0;
  int quiet = 0;

  fifo_thread_scheduler_with_io_priority dut (
    .clk, .rst, .in_valid, .in_ready, .req_type, .thread_id, .disk_ready,
    .out_valid, .out_ready, .dispatched, .dispatched_id, .from_disk_queue,
    .status, .ready_count, .disk_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sched_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .req_type, .thread_id, .disk_ready,
    .out_valid, .out_ready, .dispatched, .dispatched_id, .from_disk_queue,
    .status, .ready_count, .disk_count,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .checked, .full_drops, .disk_dispatches
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: long hold-off when asked, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic offer_request(input req_t req, input logic [7:0] id, input logic dready);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    thread_id  <= id;
    disk_ready <= dready;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Wait for every outstanding result, then let a terminate scan settle
  task automatic wait_for_results();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write: setup phase, then access until pready, then an idle phase
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Random requests in bursts that lean towards filling, draining or neither
  task automatic run_random(input int count);
    int         trend, pick;
    logic [7:0] pool[4];
    logic [7:0] id;
    req_t       req;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        trend = $urandom_range(2);
        foreach (pool[k]) pool[k] = 8'($urandom);
      end
      pick = $urandom_range(99);
      case (trend)
        0:       req = pick < 45 ? REQ_ADD : pick < 70 ? REQ_DISK :
                       pick < 90 ? REQ_YIELD : REQ_TERM;
        1:       req = pick < 15 ? REQ_ADD : pick < 25 ? REQ_DISK :
                       pick < 85 ? REQ_YIELD : REQ_TERM;
        default: req = pick < 25 ? REQ_ADD : pick < 50 ? REQ_DISK :
                       pick < 75 ? REQ_YIELD : REQ_TERM;
      endcase
      // repeated ids make terminate hit several entries
      id = ($urandom_range(9) < 7) ? pool[$urandom_range(3)] : 8'($urandom);
      offer_request(req, id, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queues, detached disk, full ready queue, terminate
    offer_request(REQ_YIELD, 8'h00, 1'b0);
    offer_request(REQ_TERM, 8'h00, 1'b0);
    offer_request(REQ_DISK, 8'hFF, 1'b1);
    offer_request(REQ_YIELD, 8'h00, 1'b1);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      case (i % 4)
        0:       offer_request(REQ_ADD, 8'h00, 1'b0);
        1:       offer_request(REQ_ADD, 8'hFF, 1'b1);
        2:       offer_request(REQ_ADD, 8'h5A, 1'b0);
        default: offer_request(REQ_ADD, 8'hA5, 1'b1);
      endcase
    offer_request(REQ_ADD, 8'h33, 1'b0);
    offer_request(REQ_TERM, 8'h5A, 1'b1);
    offer_request(REQ_TERM, 8'h12, 1'b0);
    offer_request(REQ_YIELD, 8'hFF, 1'b1);

    // Random segments over four flow-control mixes, disk attached toggling
    for (int seg = 0; seg < 8; seg++) begin
      in_valid <= 1'b0;
      wait_for_results();
      case (seg / 2)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 60; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 60; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      write_register(ADDR_DISK_ATTACHED, seg[0] ? 32'd0 : 32'd1);
      if (seg == 5) write_register(ADDR_UNMAPPED, 32'hFFFF_FFFF);
      if (seg == 0) hold_left = 300;
      run_random(SEGMENT_LEN);
    end

    in_valid <= 1'b0;
    wait_for_results();
    $display("Covered %0d requests, %0d results checked, %0d enqueues dropped when full,",
             sent, checked, full_drops);
    $display("%0d dispatches from the disk queue, disk attached and detached, four idle mixes.",
             disk_dispatches);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
